// ----- sv/hpps_pkg.sv -----
// Package for the haptic pulse pattern sequencer: shared types, codes and
// constants. No dependencies.
`default_nettype none

package hpps_pkg;

  localparam int TIME_BITS = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] RST_ALERT_GAP   = 16'd150;
  localparam logic [15:0] RST_ALERT_ON    = 16'd200;
  localparam logic [15:0] RST_PATTERN_GAP = 16'd100;
  localparam logic [15:0] RST_SHORT_ON    = 16'd100;
  localparam logic [15:0] RST_LONG_ON     = 16'd500;
  localparam logic [7:0]  RST_GENTLE      = 8'd120;

  localparam logic [7:0] DRIVE_FULL = 8'd255;
  localparam logic [7:0] DRIVE_OFF  = 8'd0;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_LONG  = 3'd4;
  localparam logic [2:0] STEP_DONE  = 3'd6;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_PULSE   = 3'd1,
    ACT_POWER   = 3'd2,
    ACT_GENTLE  = 3'd3,
    ACT_ALERT   = 3'd4,
    ACT_PATTERN = 3'd5,
    ACT_STOP    = 3'd6
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALERT_GAP   = 3'd0,
    CFG_ALERT_ON    = 3'd1,
    CFG_PATTERN_GAP = 3'd2,
    CFG_SHORT_ON    = 3'd3,
    CFG_LONG_ON     = 3'd4,
    CFG_GENTLE      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEQ_NONE    = 2'd0,
    SEQ_ALERT   = 2'd1,
    SEQ_PATTERN = 2'd2
  } seq_kind_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  power_level;
    logic [14:0] on_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic       pulse_active;
    logic       pattern_active;
  } out_item_t;

  typedef struct packed {
    logic [15:0] alert_gap_ms;
    logic [15:0] alert_on_ms;
    logic [15:0] pattern_gap_ms;
    logic [15:0] short_on_ms;
    logic [15:0] long_on_ms;
    logic [7:0]  gentle_power;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ----- sv/hpps_cfg_regs.sv -----
// Configuration register file of the haptic sequencer.
// Depends on hpps_pkg.
`default_nettype none

module hpps_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hpps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hpps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hpps_pkg::cfg_regs_t                   regs
);

  hpps_pkg::cfg_regs_t regs_r;
  hpps_pkg::cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        hpps_pkg::CFG_ALERT_GAP:   regs_nxt.alert_gap_ms   = cfg_data;
        hpps_pkg::CFG_ALERT_ON:    regs_nxt.alert_on_ms    = cfg_data;
        hpps_pkg::CFG_PATTERN_GAP: regs_nxt.pattern_gap_ms = cfg_data;
        hpps_pkg::CFG_SHORT_ON:    regs_nxt.short_on_ms    = cfg_data;
        hpps_pkg::CFG_LONG_ON:     regs_nxt.long_on_ms     = cfg_data;
        hpps_pkg::CFG_GENTLE:      regs_nxt.gentle_power   = cfg_data[7:0];
        default:                   regs_nxt = regs_r;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.alert_gap_ms   <= hpps_pkg::RST_ALERT_GAP;
      regs_r.alert_on_ms    <= hpps_pkg::RST_ALERT_ON;
      regs_r.pattern_gap_ms <= hpps_pkg::RST_PATTERN_GAP;
      regs_r.short_on_ms    <= hpps_pkg::RST_SHORT_ON;
      regs_r.long_on_ms     <= hpps_pkg::RST_LONG_ON;
      regs_r.gentle_power   <= hpps_pkg::RST_GENTLE;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/hpps_in_stage.sv -----
// Input register stage of the haptic sequencer: holds one item until the
// core takes it. Depends on hpps_pkg.
`default_nettype none

module hpps_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire hpps_pkg::in_item_t in_data,
  output logic                    item_valid,
  output hpps_pkg::in_item_t      item,
  input  wire logic               take
);

  logic               valid_r;
  logic               valid_nxt;
  hpps_pkg::in_item_t item_r;
  logic               accept;

  // stage frees up in the same cycle the core takes its item
  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/hpps_core.sv -----
// Sequencer core: millisecond clock, pulse timer, alert/pattern stepper and
// the result register. Depends on hpps_pkg.
`default_nettype none

module hpps_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hpps_pkg::cfg_regs_t regs,
  input  wire logic                item_valid,
  input  wire hpps_pkg::in_item_t  item,
  output logic                     take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hpps_pkg::out_item_t      out_data
);

  localparam int TW = hpps_pkg::TIME_BITS;

  logic [TW-1:0]       now_r, now_nxt;
  logic [TW-1:0]       pulse_start_r, pulse_start_nxt;
  logic [15:0]         pulse_len_r, pulse_len_nxt;
  logic                pulse_run_r, pulse_run_nxt;
  logic [7:0]          drive_r, drive_nxt;
  logic [TW-1:0]       step_time_r, step_time_nxt;
  hpps_pkg::seq_kind_t kind_r, kind_nxt;
  logic [2:0]          step_r, step_nxt;

  logic                out_valid_r;
  hpps_pkg::out_item_t out_data_r;

  logic [TW-1:0] now_inc;
  logic [TW-1:0] pulse_elapsed;
  logic [TW-1:0] step_elapsed;
  logic [15:0]   seq_gap;
  logic          seq_running;
  logic          pulse_expired;
  logic          step_due;
  logic [15:0]   step_on_len;

  assign take      = item_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign now_inc       = now_r + TW'(1);
  assign pulse_elapsed = now_inc - pulse_start_r;
  assign step_elapsed  = now_inc - step_time_r;
  assign seq_gap       = (kind_r == hpps_pkg::SEQ_ALERT) ? regs.alert_gap_ms
                                                         : regs.pattern_gap_ms;
  assign seq_running   = (step_r < hpps_pkg::STEP_DONE) && (kind_r != hpps_pkg::SEQ_NONE);
  assign pulse_expired = pulse_run_r && (pulse_elapsed >= TW'(pulse_len_r));
  assign step_due      = seq_running && (step_elapsed >= TW'(seq_gap));

  always_comb begin
    if (kind_r == hpps_pkg::SEQ_ALERT) begin
      step_on_len = regs.alert_on_ms;
    end else if (step_r == hpps_pkg::STEP_LONG) begin
      step_on_len = regs.long_on_ms;
    end else begin
      step_on_len = regs.short_on_ms;
    end
  end

  always_comb begin
    now_nxt         = now_r;
    pulse_start_nxt = pulse_start_r;
    pulse_len_nxt   = pulse_len_r;
    pulse_run_nxt   = pulse_run_r;
    drive_nxt       = drive_r;
    step_time_nxt   = step_time_r;
    kind_nxt        = kind_r;
    step_nxt        = step_r;
    case (item.action)
      hpps_pkg::ACT_TICK: begin
        now_nxt = now_inc;
        if (pulse_expired) begin
          drive_nxt     = hpps_pkg::DRIVE_OFF;
          pulse_run_nxt = 1'b0;
        end
        if (step_due) begin
          if (step_r[0]) begin
            drive_nxt     = hpps_pkg::DRIVE_OFF;
            pulse_run_nxt = 1'b0;
          end else begin
            drive_nxt       = hpps_pkg::DRIVE_FULL;
            pulse_start_nxt = now_inc;
            pulse_len_nxt   = step_on_len;
            pulse_run_nxt   = 1'b1;
          end
          step_time_nxt = now_inc;
          step_nxt      = step_r + 3'd1;
        end
      end
      hpps_pkg::ACT_PULSE, hpps_pkg::ACT_POWER, hpps_pkg::ACT_GENTLE: begin
        if (item.action == hpps_pkg::ACT_PULSE) begin
          drive_nxt = hpps_pkg::DRIVE_FULL;
        end else if (item.action == hpps_pkg::ACT_POWER) begin
          drive_nxt = item.power_level;
        end else begin
          drive_nxt = regs.gentle_power;
        end
        pulse_start_nxt = now_r;
        pulse_len_nxt   = {1'b0, item.on_time_ms};
        pulse_run_nxt   = 1'b1;
      end
      hpps_pkg::ACT_ALERT: begin
        kind_nxt      = hpps_pkg::SEQ_ALERT;
        step_nxt      = hpps_pkg::STEP_FIRST;
        // back-dated so the first step falls on the next tick
        step_time_nxt = now_r - TW'(regs.alert_gap_ms) - TW'(1);
      end
      hpps_pkg::ACT_PATTERN: begin
        kind_nxt      = hpps_pkg::SEQ_PATTERN;
        step_nxt      = hpps_pkg::STEP_FIRST;
        step_time_nxt = now_r - TW'(regs.pattern_gap_ms) - TW'(1);
      end
      hpps_pkg::ACT_STOP: begin
        drive_nxt     = hpps_pkg::DRIVE_OFF;
        pulse_run_nxt = 1'b0;
      end
      default: ;  // unused code: state unchanged
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      pulse_start_r <= '0;
      pulse_len_r   <= '0;
      pulse_run_r   <= 1'b0;
      drive_r       <= hpps_pkg::DRIVE_OFF;
      step_time_r   <= '0;
      kind_r        <= hpps_pkg::SEQ_NONE;
      step_r        <= hpps_pkg::STEP_DONE;
      out_valid_r   <= 1'b0;
    end else begin
      if (take) begin
        now_r         <= now_nxt;
        pulse_start_r <= pulse_start_nxt;
        pulse_len_r   <= pulse_len_nxt;
        pulse_run_r   <= pulse_run_nxt;
        drive_r       <= drive_nxt;
        step_time_r   <= step_time_nxt;
        kind_r        <= kind_nxt;
        step_r        <= step_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.drive_level    <= drive_nxt;
      out_data_r.pulse_active   <= pulse_run_nxt;
      out_data_r.pattern_active <= (kind_nxt != hpps_pkg::SEQ_NONE) &&
                                   (step_nxt < hpps_pkg::STEP_DONE);
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= hpps_pkg::STEP_DONE)
    else $error("sequence step beyond done");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.action == hpps_pkg::ACT_TICK |=> now_r == $past(now_r) + TW'(1))
    else $error("tick did not advance the clock");

  a_cmd_holds_clock: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.action != hpps_pkg::ACT_TICK |=> $stable(now_r))
    else $error("command moved the clock");

  a_pulse_full_on: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.action == hpps_pkg::ACT_PULSE
    |=> pulse_run_r && drive_r == hpps_pkg::DRIVE_FULL && out_valid_r)
    else $error("pulse command did not start a full-on pulse");

  a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.action == hpps_pkg::ACT_STOP
    |=> !pulse_run_r && drive_r == hpps_pkg::DRIVE_OFF)
    else $error("stop left the drive on");

endmodule

`default_nettype wire

// ----- sv/haptic_pulse_pattern_sequencer.sv -----
// Haptic pulse pattern sequencer, top level.
// Channels: in_valid/in_stall/in_data carry one tick or command per transfer;
// out_valid/out_stall/out_data return exactly one result per input item, in
// order: drive level, pulse running flag and pattern running flag after the
// item. cfg_valid/cfg_ready/cfg_index/cfg_data write the six timing and level
// registers; cfg_ready is always high, and writes belong in idle periods.
// An accepted item waits in the input register, then moves into the result
// register when the core takes it; out_valid rises as it enters there.
// Throughput: one item per cycle while out_stall is low.
// Reset (synchronous, rst_n low): clock and timers at zero, motor off, no
// sequence running, registers back to their defaults; no result pending.
// When the receiver stalls, the result register holds its value, the input
// register holds one further item, and in_stall rises once both are full.
// Depends on hpps_pkg, hpps_cfg_regs, hpps_in_stage and hpps_core.
`default_nettype none

module haptic_pulse_pattern_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire hpps_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output hpps_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hpps_pkg::CFG_DATA_W-1:0] cfg_data
);

  hpps_pkg::cfg_regs_t regs;
  hpps_pkg::in_item_t  item;
  logic                item_valid;
  logic                take;

  hpps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  hpps_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  hpps_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for haptic_pulse_pattern_sequencer: directed table, then random
// ticks and commands over several register settings, checked against an in-bench predictor.
// Depends on hpps_pkg and the haptic_pulse_pattern_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
  import hpps_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic       TYPED      = 1'b1;
  localparam logic       PREDICTED  = 1'b0;
  localparam int         PHASES     = 10;
  localparam int         PHASE_ITEMS = 170;
  localparam int         HOLD_CYCLES = 80;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  // item, typed flag, then drive level / pulse flag / sequence flag where typed
  localparam int PLAN_ROWS = 18;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    {ACT_STOP,    8'h00, 15'h0000, TYPED,     8'd0,   1'b0, 1'b0},
    {ACT_PULSE,   8'h00, 15'h0000, TYPED,     8'd255, 1'b1, 1'b0},
    {ACT_TICK,    8'hFF, 15'h7FFF, TYPED,     8'd0,   1'b0, 1'b0},
    {ACT_POWER,   8'hFF, 15'h7FFF, TYPED,     8'd255, 1'b1, 1'b0},
    {ACT_POWER,   8'h00, 15'h7FFF, TYPED,     8'd0,   1'b1, 1'b0},
    {ACT_GENTLE,  8'h55, 15'h2AAA, TYPED,     8'd120, 1'b1, 1'b0},
    {ACT_UNUSED,  8'hAA, 15'h5555, TYPED,     8'd120, 1'b1, 1'b0},
    {ACT_TICK,    8'h00, 15'h0000, PREDICTED, 10'd0},
    {ACT_STOP,    8'hFF, 15'h7FFF, TYPED,     8'd0,   1'b0, 1'b0},
    {ACT_ALERT,   8'h00, 15'h0000, TYPED,     8'd0,   1'b0, 1'b1},
    {ACT_TICK,    8'h00, 15'h0000, TYPED,     8'd255, 1'b1, 1'b1},
    {ACT_TICK,    8'h00, 15'h0000, PREDICTED, 10'd0},
    {ACT_PATTERN, 8'hFF, 15'h7FFF, PREDICTED, 10'd0},
    {ACT_TICK,    8'h00, 15'h0000, PREDICTED, 10'd0},
    {ACT_STOP,    8'h00, 15'h0000, TYPED,     8'd0,   1'b0, 1'b1},
    {ACT_POWER,   8'h80, 15'h0001, PREDICTED, 10'd0},
    {ACT_TICK,    8'h00, 15'h0000, PREDICTED, 10'd0},
    {ACT_TICK,    8'h00, 15'h0000, PREDICTED, 10'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  haptic_pulse_pattern_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [TIME_BITS-1:0] m_now, m_pulse_start, m_step_time;
  logic [15:0]          m_pulse_len;
  logic                 m_pulse_on;
  logic [7:0]           m_drive;
  seq_kind_t            m_kind;
  logic [2:0]           m_step;
  cfg_regs_t            m_cfg;

  out_item_t   pending_levels[$];
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic void start_pulse(input logic [7:0] lvl, input logic [15:0] len);
    m_drive       = lvl;
    m_pulse_start = m_now;
    m_pulse_len   = len;
    m_pulse_on    = 1'b1;
  endfunction

  function automatic void halt_motor();
    m_drive    = DRIVE_OFF;
    m_pulse_on = 1'b0;
  endfunction

  function automatic void start_sequence(input seq_kind_t kind, input logic [15:0] gap);
    m_kind      = kind;
    m_step      = STEP_FIRST;
    m_step_time = m_now - TIME_BITS'(gap) - 1;
  endfunction

  function automatic out_item_t predict_drive(input in_item_t it);
    out_item_t            res;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] gap;
    case (it.action)
      ACT_TICK: begin
        m_now   = m_now + 1;
        elapsed = m_now - m_pulse_start;
        if (m_pulse_on && elapsed >= TIME_BITS'(m_pulse_len)) halt_motor();
        if (m_step < STEP_DONE && m_kind != SEQ_NONE) begin
          gap = (m_kind == SEQ_ALERT) ? TIME_BITS'(m_cfg.alert_gap_ms)
                                      : TIME_BITS'(m_cfg.pattern_gap_ms);
          elapsed = m_now - m_step_time;
          if (elapsed >= gap) begin
            if (m_step[0]) begin
              halt_motor();
            end else if (m_kind == SEQ_ALERT) begin
              start_pulse(DRIVE_FULL, m_cfg.alert_on_ms);
            end else begin
              start_pulse(DRIVE_FULL, (m_step == STEP_LONG) ? m_cfg.long_on_ms
                                                             : m_cfg.short_on_ms);
            end
            m_step_time = m_now;
            m_step      = m_step + 3'd1;
          end
        end
      end
      ACT_PULSE:   start_pulse(DRIVE_FULL, {1'b0, it.on_time_ms});
      ACT_POWER:   start_pulse(it.power_level, {1'b0, it.on_time_ms});
      ACT_GENTLE:  start_pulse(m_cfg.gentle_power, {1'b0, it.on_time_ms});
      ACT_ALERT:   start_sequence(SEQ_ALERT, m_cfg.alert_gap_ms);
      ACT_PATTERN: start_sequence(SEQ_PATTERN, m_cfg.pattern_gap_ms);
      ACT_STOP:    halt_motor();
      default: ;   // unused code leaves state alone
    endcase
    res.drive_level    = m_drive;
    res.pulse_active   = m_pulse_on;
    res.pattern_active = (m_kind != SEQ_NONE) && (m_step < STEP_DONE);
    return res;
  endfunction

  // mostly ticks so sequences and pulse timers run their course
  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 62)      it.action = ACT_TICK;
    else if (roll < 68) it.action = ACT_PULSE;
    else if (roll < 73) it.action = ACT_POWER;
    else if (roll < 77) it.action = ACT_GENTLE;
    else if (roll < 82) it.action = ACT_ALERT;
    else if (roll < 87) it.action = ACT_PATTERN;
    else if (roll < 97) it.action = ACT_STOP;
    else                it.action = ACT_UNUSED;
    it.power_level = 8'($urandom);
    it.on_time_ms  = ($urandom_range(99, 0) < 80) ? 15'($urandom_range(20, 0))
                                                  : 15'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t res;
    logic      taken;
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    res = predict_drive(it);
    pending_levels.push_back(typed ? want : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALERT_GAP:   m_cfg.alert_gap_ms   = val;
      CFG_ALERT_ON:    m_cfg.alert_on_ms    = val;
      CFG_PATTERN_GAP: m_cfg.pattern_gap_ms = val;
      CFG_SHORT_ON:    m_cfg.short_on_ms    = val;
      CFG_LONG_ON:     m_cfg.long_on_ms     = val;
      CFG_GENTLE:      m_cfg.gentle_power   = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall plus one long hold-off to back up the input
  initial begin
    int unsigned hold_left;
    logic        hold_used;
    out_item_t   want;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_used && results_checked >= 500) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (recv_idle_pct != 0) && ($urandom_range(99, 0) < recv_idle_pct);
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_levels.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = pending_levels.pop_front();
          if (out_data.drive_level !== want.drive_level)
            report_mismatch($sformatf("drive_level got %0d want %0d",
                                      out_data.drive_level, want.drive_level));
          if (out_data.pulse_active !== want.pulse_active)
            report_mismatch($sformatf("pulse_active got %0b want %0b",
                                      out_data.pulse_active, want.pulse_active));
          if (out_data.pattern_active !== want.pattern_active)
            report_mismatch($sformatf("pattern_active got %0b want %0b",
                                      out_data.pattern_active, want.pattern_active));
        end
      end
    end
  end

  initial begin
    cfg_regs_t   pc;
    int unsigned ph;
    int unsigned k;
    m_now       = '0;
    m_pulse_start = '0;
    m_step_time = '0;
    m_pulse_len = '0;
    m_pulse_on  = 1'b0;
    m_drive     = DRIVE_OFF;
    m_kind      = SEQ_NONE;
    m_step      = STEP_DONE;
    m_cfg       = {RST_ALERT_GAP, RST_ALERT_ON, RST_PATTERN_GAP,
                   RST_SHORT_ON, RST_LONG_ON, RST_GENTLE};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 10;
    recv_idle_pct   = 59;
    for (k = 0; k < PLAN_ROWS; k++) send_item(PLAN[k].item, PLAN[k].typed, PLAN[k].want);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        sender_idle_pct = 10;
        recv_idle_pct   = 59;
      end else if (ph < 6) begin
        sender_idle_pct = 59;
        recv_idle_pct   = 10;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      // fields: alert gap, alert on, pattern gap, short on, long on, gentle
      case (ph)
        0: pc = {16'd3, 16'd2, 16'd4, 16'd1, 16'd6, 8'd0};
        1: pc = {16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 8'd255};
        2: pc = {16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 8'd1};
        3: pc = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'd128};
        default: pc = {16'($urandom_range(12, 1)), 16'($urandom_range(15, 0)),
                       16'($urandom_range(12, 1)), 16'($urandom_range(15, 0)),
                       16'($urandom_range(20, 0)), 8'($urandom)};
      endcase
      write_reg(CFG_ALERT_GAP, pc.alert_gap_ms);
      write_reg(CFG_ALERT_ON, pc.alert_on_ms);
      write_reg(CFG_PATTERN_GAP, pc.pattern_gap_ms);
      write_reg(CFG_SHORT_ON, pc.short_on_ms);
      write_reg(CFG_LONG_ON, pc.long_on_ms);
      write_reg(CFG_GENTLE, {8'($urandom), pc.gentle_power});
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_command(), PREDICTED, '0);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("haptic_pulse_pattern_sequencer verification clean");
    end else begin
      $display("haptic_pulse_pattern_sequencer verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("haptic_pulse_pattern_sequencer verification failed");
    $finish;
  end

endmodule

// ----- haptic_pulse_pattern_sequencer.f -----
sv/hpps_pkg.sv
sv/hpps_cfg_regs.sv
sv/hpps_in_stage.sv
sv/hpps_core.sv
sv/haptic_pulse_pattern_sequencer.sv
bench/tb_top.sv
